[rtl/mf3_pkg.sv]
package mf3_pkg;

  // Line store depth: widest row the block can filter
  localparam int MAX_WIDTH  = 1024;
  localparam int WIDTH_CAP  = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
  localparam int ADDR_W     = $clog2(WIDTH_CAP);
  localparam int HEIGHT_CAP = 1024;

  localparam int PIX_W = 8;
  localparam int POS_W = 10;
  localparam int DIM_W = 11;

  localparam logic [DIM_W-1:0] DIM_MIN        = DIM_W'(3);
  localparam logic [DIM_W-1:0] WIDTH_MAX      = DIM_W'(WIDTH_CAP);
  localparam logic [DIM_W-1:0] HEIGHT_MAX     = DIM_W'(HEIGHT_CAP);
  localparam logic [DIM_W-1:0] WIDTH_RST      = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RST     = DIM_W'(480);

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_ROW_PIXELS = 1'b0,
    CFG_FRAME_ROWS = 1'b1
  } cfg_reg_e;

  // Position and tagging of one pixel beat
  typedef struct packed {
    logic             emit;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             done;
  } meta_t;

  // One entry of the line store: pixels of rows r-2 and r-1
  typedef struct packed {
    logic [PIX_W-1:0] upper;
    logic [PIX_W-1:0] middle;
  } lb_word_t;

  // One window column, top to bottom
  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] px;
  } col_t;

  // Three values in ascending order
  typedef struct packed {
    logic [PIX_W-1:0] lo;
    logic [PIX_W-1:0] md;
    logic [PIX_W-1:0] hi;
  } trio_t;

  function automatic logic [PIX_W-1:0] min2(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [PIX_W-1:0] max2(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b);
    return (a < b) ? b : a;
  endfunction

  function automatic trio_t sort3(input logic [PIX_W-1:0] a,
                                  input logic [PIX_W-1:0] b,
                                  input logic [PIX_W-1:0] c);
    trio_t t;
    logic [PIX_W-1:0] lo_ab;
    logic [PIX_W-1:0] hi_ab;
    lo_ab = min2(a, b);
    hi_ab = max2(a, b);
    t.hi  = max2(hi_ab, c);
    t.lo  = min2(lo_ab, c);
    t.md  = max2(lo_ab, min2(hi_ab, c));
    return t;
  endfunction

  function automatic logic [PIX_W-1:0] med3(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b,
                                            input logic [PIX_W-1:0] c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

endpackage

[rtl/mf3_linebuf.sv]
module mf3_linebuf (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     rd_en_i,
  input  logic [mf3_pkg::ADDR_W-1:0] rd_addr_i,
  output mf3_pkg::lb_word_t        rd_data_o,
  input  logic                     wr_en_i,
  input  logic [mf3_pkg::ADDR_W-1:0] wr_addr_i,
  input  mf3_pkg::lb_word_t        wr_data_i
);
  import mf3_pkg::*;

  lb_word_t mem_q [WIDTH_CAP];
  lb_word_t ram_rd_q;
  lb_word_t fwd_data_q;
  logic     fwd_q;

  // Write back and read one entry per cycle; the read sees the old contents
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      ram_rd_q <= mem_q[rd_addr_i];
    end
  end

  // Catch a read of the entry being written on the same edge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      fwd_data_q <= wr_data_i;
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : ram_rd_q;

endmodule

[rtl/mf3_median.sv]
module mf3_median (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  mf3_pkg::col_t                in_col_i,
  input  mf3_pkg::meta_t               in_meta_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [mf3_pkg::PIX_W-1:0]    median_o,
  output logic [mf3_pkg::POS_W-1:0]    center_row_o,
  output logic [mf3_pkg::POS_W-1:0]    center_col_o,
  output logic                         frame_done_o
);
  import mf3_pkg::*;

  logic [PIX_W-1:0] win_q [9];
  logic [PIX_W-1:0] win_d [9];
  logic             s2_v_q;
  meta_t            s2_meta_q;
  logic             s3_v_q;
  meta_t            s3_meta_q;
  trio_t            s3_col_q [3];
  logic             s4_v_q;
  meta_t            s4_meta_q;
  logic [PIX_W-1:0] s4_lo_q;
  logic [PIX_W-1:0] s4_md_q;
  logic [PIX_W-1:0] s4_hi_q;
  logic             out_v_q;
  meta_t            out_meta_q;
  logic [PIX_W-1:0] out_med_q;
  logic             out_free;
  logic             s4_free;
  logic             s3_free;
  logic             s2_free;

  // Stage moves when it is empty or its content moves on
  assign out_free   = !out_v_q || !out_stall_i;
  assign s4_free    = !s4_v_q || out_free;
  assign s3_free    = !s3_v_q || s4_free;
  assign s2_free    = !s2_v_q || s3_free;
  assign in_stall_o = !s2_free;

  // Shift the window one column left and append the new column
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      win_d[i] = win_q[i+3];
    end
    win_d[6] = in_col_i.top;
    win_d[7] = in_col_i.mid;
    win_d[8] = in_col_i.px;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
    end else if (in_valid_i && s2_free) begin
      win_q <= win_d;
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s2_free) begin
        s2_v_q <= in_valid_i;
      end
      // Drop border beats once they have updated the window
      if (s3_free) begin
        s3_v_q <= s2_v_q && s2_meta_q.emit;
      end
      if (s4_free) begin
        s4_v_q <= s3_v_q;
      end
      if (out_free) begin
        out_v_q <= s4_v_q;
      end
    end
  end

  // Sorting network: sort columns, then reduce to the median of three
  always_ff @(posedge clk_i) begin
    if (in_valid_i && s2_free) begin
      s2_meta_q <= in_meta_i;
    end
    if (s2_v_q && s3_free) begin
      s3_meta_q <= s2_meta_q;
      for (int k = 0; k < 3; k++) begin
        s3_col_q[k] <= sort3(win_q[3*k], win_q[3*k+1], win_q[3*k+2]);
      end
    end
    if (s3_v_q && s4_free) begin
      s4_meta_q <= s3_meta_q;
      s4_lo_q   <= max2(max2(s3_col_q[0].lo, s3_col_q[1].lo), s3_col_q[2].lo);
      s4_md_q   <= med3(s3_col_q[0].md, s3_col_q[1].md, s3_col_q[2].md);
      s4_hi_q   <= min2(min2(s3_col_q[0].hi, s3_col_q[1].hi), s3_col_q[2].hi);
    end
    if (s4_v_q && out_free) begin
      out_meta_q <= s4_meta_q;
      out_med_q  <= med3(s4_lo_q, s4_md_q, s4_hi_q);
    end
  end

  assign out_valid_o  = out_v_q;
  assign median_o     = out_med_q;
  assign center_row_o = out_meta_q.row;
  assign center_col_o = out_meta_q.col;
  assign frame_done_o = out_meta_q.done;

endmodule

[rtl/median_filter_3x3.sv]
// Streaming 3x3 median filter for 8-bit grey pixels in raster order, one pixel
// beat per clock sustained while out_stall_i is low. Each pixel at row r >= 2,
// column c >= 2 completes the window around (r-1, c-1) and yields one result
// beat, the fifth smallest of the nine pixels, which passes the holding stage,
// the window register and the comparator stages; border pixels yield nothing.
// A single line store memory (one read and one write per cycle, same-entry
// hazard forwarded) keeps the two previous rows, and three comparator stages
// follow the window register. frame_start_i restarts the frame at (0,0);
// without it the position wraps after the last pixel. The row length
// (register 0) and the row count (register 1) are clamped to 3..1024 and must
// only be written while no pixel is in flight. No clearing pass after reset:
// line store contents feed a result only after the two rows above were written.
module median_filter_3x3 (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [0:0]                   cfg_index_i,
  input  logic [mf3_pkg::DIM_W-1:0]    cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [mf3_pkg::PIX_W-1:0]    pixel_i,
  input  logic                         frame_start_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [mf3_pkg::PIX_W-1:0]    median_o,
  output logic [mf3_pkg::POS_W-1:0]    center_row_o,
  output logic [mf3_pkg::POS_W-1:0]    center_col_o,
  output logic                         frame_done_o
);
  import mf3_pkg::*;

  logic [DIM_W-1:0] width_q;
  logic [DIM_W-1:0] height_q;
  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;
  logic [POS_W-1:0] col_q;
  logic [POS_W-1:0] col_d;
  logic [POS_W-1:0] row_q;
  logic [POS_W-1:0] row_d;
  logic [POS_W-1:0] col_base;
  logic [DIM_W-1:0] row_base;
  logic [POS_W-1:0] col_cur;
  logic [DIM_W-1:0] row_wrap;
  logic [DIM_W-1:0] row_cur;
  logic [DIM_W-1:0] col_inc;
  logic [DIM_W-1:0] row_inc;
  meta_t            meta_cur;
  logic             acc;
  logic             s1_v_q;
  logic [PIX_W-1:0] s1_px_q;
  logic [ADDR_W-1:0] s1_addr_q;
  meta_t            s1_meta_q;
  logic             s1_fire;
  logic             med_stall;
  lb_word_t         lb_rd;
  lb_word_t         lb_wr;
  col_t             s1_col;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_ROW_PIXELS: width_q  <= cfg_data_i;
        CFG_FRAME_ROWS: height_q <= cfg_data_i;
      endcase
    end
  end

  // Clamp the frame size
  always_comb begin
    if (width_q < DIM_MIN) begin
      w_eff = DIM_MIN;
    end else if (width_q > WIDTH_MAX) begin
      w_eff = WIDTH_MAX;
    end else begin
      w_eff = width_q;
    end
    if (height_q < DIM_MIN) begin
      h_eff = DIM_MIN;
    end else if (height_q > HEIGHT_MAX) begin
      h_eff = HEIGHT_MAX;
    end else begin
      h_eff = height_q;
    end
  end

  // Place the incoming pixel and step the raster position
  always_comb begin
    col_base = frame_start_i ? '0 : col_q;
    row_base = frame_start_i ? '0 : {1'b0, row_q};
    if ({1'b0, col_base} >= w_eff) begin
      col_cur  = '0;
      row_wrap = row_base + DIM_W'(1);
    end else begin
      col_cur  = col_base;
      row_wrap = row_base;
    end
    row_cur = (row_wrap >= h_eff) ? '0 : row_wrap;

    col_inc = {1'b0, col_cur} + DIM_W'(1);
    row_inc = row_cur + DIM_W'(1);
    if (col_inc >= w_eff) begin
      col_d = '0;
      row_d = (row_inc >= h_eff) ? '0 : row_inc[POS_W-1:0];
    end else begin
      col_d = col_inc[POS_W-1:0];
      row_d = row_cur[POS_W-1:0];
    end

    meta_cur.emit = (row_cur >= DIM_W'(2)) && (col_cur >= POS_W'(2));
    meta_cur.row  = row_cur[POS_W-1:0] - POS_W'(1);
    meta_cur.col  = col_cur - POS_W'(1);
    meta_cur.done = (row_cur == h_eff - DIM_W'(1)) &&
                    ({1'b0, col_cur} == w_eff - DIM_W'(1));
  end

  assign in_stall_o = s1_v_q && med_stall;
  assign acc        = in_valid_i && !in_stall_o;
  assign s1_fire    = s1_v_q && !med_stall;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      s1_v_q <= 1'b0;
    end else begin
      if (acc) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (acc) begin
        s1_v_q <= 1'b1;
      end else if (s1_fire) begin
        s1_v_q <= 1'b0;
      end
    end
  end

  // Hold the beat while its line store read is in flight
  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_px_q   <= pixel_i;
      s1_addr_q <= col_cur[ADDR_W-1:0];
      s1_meta_q <= meta_cur;
    end
  end

  // Rotate the column: middle row moves up, new pixel becomes the middle row
  assign lb_wr.upper  = lb_rd.middle;
  assign lb_wr.middle = s1_px_q;
  assign s1_col.top   = lb_rd.upper;
  assign s1_col.mid   = lb_rd.middle;
  assign s1_col.px    = s1_px_q;

  mf3_linebuf u_linebuf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (acc),
    .rd_addr_i (col_cur[ADDR_W-1:0]),
    .rd_data_o (lb_rd),
    .wr_en_i   (s1_fire),
    .wr_addr_i (s1_addr_q),
    .wr_data_i (lb_wr)
  );

  mf3_median u_median (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s1_v_q),
    .in_stall_o   (med_stall),
    .in_col_i     (s1_col),
    .in_meta_i    (s1_meta_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .median_o     (median_o),
    .center_row_o (center_row_o),
    .center_col_o (center_col_o),
    .frame_done_o (frame_done_o)
  );

  // The accepted pixel always lands inside the row
  a_col_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |-> ({1'b0, col_cur} < w_eff))
    else $error("pixel column beyond frame width");

  // An empty holding stage never stalls the input
  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_v_q |-> !in_stall_o)
    else $error("input stalled with empty holding stage");

  // Result centers lie in the interior of the frame
  a_center_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (center_col_o != '0) && (center_row_o != '0) &&
                    ({1'b0, center_col_o} <= w_eff - DIM_W'(2)) &&
                    ({1'b0, center_row_o} <= h_eff - DIM_W'(2)))
    else $error("result center outside frame interior");

  // The frame-done beat is the bottom-right interior pixel
  a_done_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_done_o) |->
      ({1'b0, center_col_o} == w_eff - DIM_W'(2)) &&
      ({1'b0, center_row_o} == h_eff - DIM_W'(2)))
    else $error("frame done flagged away from last interior pixel");

endmodule
